// ===== sv/wcdc_pkg.sv =====
// wcdc_pkg: shared types and constants for the window class diversity counter
// no dependencies; imported by every module of the block
`default_nettype none

package wcdc_pkg;

    localparam int CODE_W = 16;
    localparam int DIV_W = 6;
    localparam int DIV_MAX = 63;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS_OF_INTEREST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CLASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ENABLE = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] class_of_interest;
        logic [CODE_W-1:0] ignore_class;
        logic              ignore_enable;
    } cfg_t;

    typedef struct packed {
        logic [DIV_W-1:0] diversity;
        logic             overflow;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/wcdc_cfg.sv =====
// wcdc_cfg: configuration register file written over the config channel
// depends on wcdc_pkg
`default_nettype none

module wcdc_cfg
    import wcdc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CODE_W-1:0]    wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_CLASS_OF_INTEREST: cfg_next.class_of_interest = wr_data;
                REG_IGNORE_CLASS:      cfg_next.ignore_class = wr_data;
                REG_IGNORE_ENABLE:     cfg_next.ignore_enable = wr_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/wcdc_window.sv =====
// wcdc_window: distinct code store with parallel match, window flags and result logic
// depends on wcdc_pkg
`default_nettype none

module wcdc_window
    import wcdc_pkg::*;
#(
    parameter int MAX_DISTINCT = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [CODE_W-1:0] code,
    input  wire logic              last,
    input  cfg_t                   cfg,
    output result_t                result
);

    localparam int CNT_W = $clog2(MAX_DISTINCT + 1);
    localparam int IDX_W = $clog2(MAX_DISTINCT);
    localparam int WIDE_W = (CNT_W > DIV_W) ? CNT_W : DIV_W + 1;

    logic [CODE_W-1:0] store_reg [MAX_DISTINCT];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              interest_reg;
    logic              interest_next;
    logic              ignore_reg;
    logic              ignore_next;
    logic              ovf_reg;
    logic              ovf_next;

    logic              found;
    logic              full;
    logic              insert;
    logic [CNT_W-1:0]  total;
    logic              interest_now;
    logic              ignore_now;
    logic              ovf_now;
    logic [WIDE_W-1:0] div_wide;

    always_comb
    begin
        found = 1'b0;
        for (int k = 0; k < MAX_DISTINCT; k++)
        begin
            if ((CNT_W'(k) < count_reg) && (store_reg[k] == code))
            begin
                found = 1'b1;
            end
        end
    end

    assign full = (count_reg == CNT_W'(MAX_DISTINCT));
    assign insert = !found && !full;
    assign total = count_reg + {{(CNT_W-1){1'b0}}, insert};
    assign interest_now = interest_reg || (code == cfg.class_of_interest);
    assign ignore_now = ignore_reg || (code == cfg.ignore_class);
    assign ovf_now = ovf_reg || (!found && full);

    always_comb
    begin
        if (!interest_now)
        begin
            div_wide = WIDE_W'(1);
        end
        else if (ovf_now)
        begin
            div_wide = WIDE_W'(MAX_DISTINCT);
        end
        else if (cfg.ignore_enable && ignore_now && (total != '0))
        begin
            div_wide = WIDE_W'(total) - WIDE_W'(1);
        end
        else
        begin
            div_wide = WIDE_W'(total);
        end
        if (div_wide > WIDE_W'(DIV_MAX))
        begin
            div_wide = WIDE_W'(DIV_MAX);
        end
    end

    assign result.diversity = div_wide[DIV_W-1:0];
    assign result.overflow = interest_now && ovf_now;

    always_comb
    begin
        count_next = count_reg;
        interest_next = interest_reg;
        ignore_next = ignore_reg;
        ovf_next = ovf_reg;
        if (step)
        begin
            if (last)
            begin
                count_next = '0;
                interest_next = 1'b0;
                ignore_next = 1'b0;
                ovf_next = 1'b0;
            end
            else
            begin
                count_next = total;
                interest_next = interest_now;
                ignore_next = ignore_now;
                ovf_next = ovf_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            interest_reg <= 1'b0;
            ignore_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            interest_reg <= interest_next;
            ignore_reg <= ignore_next;
            ovf_reg <= ovf_next;
        end
    end

    // store entries above the fill count are never matched
    always_ff @(posedge clk)
    begin
        if (step && insert)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= code;
        end
    end

endmodule

`default_nettype wire

// ===== sv/window_class_diversity_counter.sv =====
// window_class_diversity_counter: top level with input and result registers
// depends on wcdc_pkg, wcdc_cfg and wcdc_window
//
// usage
// - s_axis carries one class code per item in tdata, tlast marks the final code of a window
// - m_axis carries one result per window: diversity and overflow in tdata
// - cfg channel writes class_of_interest (0), ignore_class (1), ignore_enable (2);
//   cfg_ready is always high; user must write only while the stream is idle, unchecked
// - throughput: one code per cycle while no final code stalls; each code is matched
//   against all stored distinct codes at once, so the store compare sets the cycle
// - path: a code is held in the input register, and the result of a final
//   code is captured in the output register that drives m_axis
// - when m_tready is low and a result waits, non-final codes keep flowing;
//   a final code held in the input register stops s_tready until the result leaves
// - reset clears config registers, window state and both valid flags;
//   no clearing pass, the store is tracked by a fill count
`default_nettype none

module window_class_diversity_counter
    import wcdc_pkg::*;
#(
    parameter int MAX_DISTINCT = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // class_code[15:0]
    input  wire logic                 s_tlast,   // last_of_window
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // diversity[5:0], overflow[6], zero[7]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CODE_W-1:0]    cfg_data
);

    cfg_t              cfg;
    result_t           result;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CODE_W-1:0] in_code_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;

    logic              advance;
    logic              s_accept;

    assign cfg_ready = 1'b1;

    wcdc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    wcdc_window #(
        .MAX_DISTINCT (MAX_DISTINCT)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_valid_reg && advance),
        .code   (in_code_reg),
        .last   (in_last_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance = !in_last_reg || !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_valid_reg && in_last_reg && advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_code_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (in_valid_reg && in_last_reg && advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, out_data_reg.overflow, out_data_reg.diversity};

    // overflow only comes with a saturated count
    a_ovf_count : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[6]) |->
        (m_tdata[5:0] == ((MAX_DISTINCT > DIV_MAX) ? DIV_W'(DIV_MAX) : DIV_W'(MAX_DISTINCT))))
        else $error("overflow result without saturated diversity");

    // a new result only follows a final code
    a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result appeared without a final code");

    // a blocked final code stays in the input register
    a_last_held : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && !advance) |=> (in_valid_reg && in_last_reg))
        else $error("stalled final code lost");

endmodule

`default_nettype wire
